// ===== design/assert_macros.svh =====
// Assertion macros shared by the sampler RTL.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of i_clk, disabled while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== design/bis_pkg.sv =====
// Package for the bilinear image sampler: sizes, codes and shared types.
// No dependencies; the interfaces, the RTL modules and the testbench use it.
`timescale 1ns / 1ps

package bis_pkg;

    // Frame store geometry and position format.
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WIDTH  = 256;
    localparam int FRAC_BITS  = 8;

    // Pixel format.
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = NUM_CHAN * CHAN_W;

    // Field widths fixed by the request and register formats.
    localparam int POS_W   = 9;
    localparam int SIZE_W  = 9;
    localparam int MODE_W  = 2;
    localparam int COORD_W = 17;

    // Integer part of a position, and a neighbor row or column (one more bit).
    localparam int INT_W = COORD_W - FRAC_BITS;
    localparam int NB_W  = INT_W + 1;

    // Store addressing.
    localparam int ROW_AW = $clog2(MAX_HEIGHT);
    localparam int COL_AW = $clog2(MAX_WIDTH);
    localparam int ADDR_W = ROW_AW + COL_AW;
    localparam int DEPTH  = 1 << ADDR_W;

    // Common width for range compares.
    localparam int MAXH_W = $clog2(MAX_HEIGHT + 1);
    localparam int MAXW_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_A  = (NB_W > SIZE_W) ? NB_W : SIZE_W;
    localparam int CMP_B  = (MAXH_W > MAXW_W) ? MAXH_W : MAXW_W;
    localparam int CMP_C  = (CMP_A > CMP_B) ? CMP_A : CMP_B;
    localparam int CMP_W  = (CMP_C > POS_W) ? CMP_C : POS_W;

    // Blend arithmetic.
    localparam int SCALE = 1 << FRAC_BITS;
    localparam int HALF  = 1 << (FRAC_BITS - 1);
    localparam int WT_W  = FRAC_BITS + 1;
    localparam int TOP_W = FRAC_BITS + CHAN_W + 1;
    localparam int SUM_W = 2 * FRAC_BITS + CHAN_W + 1;

    // Neighbor fetch sequence: upper-left, upper-right, lower-left, lower-right.
    localparam int NUM_NB   = 4;
    localparam int NB_IDX_W = $clog2(NUM_NB);
    localparam int NB_UL    = 0;
    localparam int NB_UR    = 1;
    localparam int NB_BL    = 2;
    localparam int NB_BR    = 3;
    localparam logic [NB_IDX_W-1:0] NB_LAST = NB_IDX_W'(NUM_NB - 1);
    // Bit of the neighbor index that selects the lower row, and the right column.
    localparam int NB_ROW_BIT = 1;
    localparam int NB_COL_BIT = 0;
    // Capture plus two lane stages after the last read.
    localparam logic [NB_IDX_W-1:0] CALC_LAST = NB_IDX_W'(2);

    // Configuration port.
    localparam int NUM_REGS  = 3;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_MODE   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = REG_IDX_W'(2);

    // Interpolation modes; the two remaining codes both return white.
    localparam logic [MODE_W-1:0] MODE_NEAREST  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_BILINEAR = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_WHITE    = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_RESERVED = MODE_W'(3);

    localparam logic [MODE_W-1:0] MODE_RESET   = MODE_BILINEAR;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(256);

    // Request kinds.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef logic [CHAN_W-1:0] t_chan;

    // Fraction weights handed to each channel lane.
    typedef struct packed {
        logic [FRAC_BITS-1:0] fy;
        logic [FRAC_BITS-1:0] fx;
    } t_weights;

endpackage

// ===== design/bis_if.sv =====
// Handshake interfaces for the sampler request and result channels.
// Depends on bis_pkg for field widths.
`timescale 1ns / 1ps

interface bis_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [bis_pkg::POS_W-1:0]        pixel_row;
    logic [bis_pkg::POS_W-1:0]        pixel_col;
    logic [bis_pkg::CHAN_W-1:0]       pixel_c0;
    logic [bis_pkg::CHAN_W-1:0]       pixel_c1;
    logic [bis_pkg::CHAN_W-1:0]       pixel_c2;
    logic [bis_pkg::COORD_W-1:0]      sample_y;
    logic [bis_pkg::COORD_W-1:0]      sample_x;

    modport source (
        output valid, req_type, pixel_row, pixel_col, pixel_c0, pixel_c1, pixel_c2,
               sample_y, sample_x,
        input  ready
    );
    modport sink (
        input  valid, req_type, pixel_row, pixel_col, pixel_c0, pixel_c1, pixel_c2,
               sample_y, sample_x,
        output ready
    );
endinterface

interface bis_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bis_pkg::CHAN_W-1:0] out_c0;
    logic [bis_pkg::CHAN_W-1:0] out_c1;
    logic [bis_pkg::CHAN_W-1:0] out_c2;

    modport source (
        output valid, out_c0, out_c1, out_c2,
        input  ready
    );
    modport sink (
        input  valid, out_c0, out_c1, out_c2,
        output ready
    );
endinterface

// ===== design/bilinear_image_sampler_unit.sv =====
// Top level of the bilinear image sampler: config registers, fetch sequencer,
// channel lanes and the merging output stage. Depends on bis_pkg, bis_if,
// bis_frame_store, bis_lane and assert_macros.svh.
//
//   Channel   Direction  Handshake                     Carries
//   i_req     in         valid/ready                   pixel write or sample request
//   o_rsp     out        valid/ready                   one sampled pixel per sample
//   APB       in/out     psel/penable/pwrite, pready   mode, image height, image width
//
// A write request is accepted in the idle state and produces no result. A sample
// request occupies the block from its acceptance through four reads of the
// single-port frame store (one per neighbor), a capture of the last neighbor, two
// lane multiply stages and the load of the output register. White mode goes from
// acceptance straight to that load. Reset clears control state only; the frame
// store is not cleared. The output register lets a new request enter while a
// result waits; a sample that finishes while the previous result is still
// unclaimed holds in its last state until the output register frees up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bilinear_image_sampler_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bis_req_if.sink                       i_req,
    bis_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bis_pkg::PADDR_W-1:0]   paddr,
    input  logic [bis_pkg::PDATA_W-1:0]   pwdata,
    output logic [bis_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import bis_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CALC = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers. The APB port never stalls; writes land on
    // the access cycle and reads return the stored value.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]    r_mode;
    logic [SIZE_W-1:0]    r_height;
    logic [SIZE_W-1:0]    r_width;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RESET;
            r_height <= HEIGHT_RESET;
            r_width  <= WIDTH_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MODE:   r_mode   <= pwdata[MODE_W-1:0];
                REG_HEIGHT: r_height <= pwdata[SIZE_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MODE:   prdata = PDATA_W'(r_mode);
            REG_HEIGHT: prdata = PDATA_W'(r_height);
            REG_WIDTH:  prdata = PDATA_W'(r_width);
            default:    prdata = '0;
        endcase
    end

    // Image size as seen by the sampler, clipped to what the store holds.
    logic [CMP_W-1:0] h_eff;
    logic [CMP_W-1:0] w_eff;

    assign h_eff = (CMP_W'(r_height) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT)
                                                          : CMP_W'(r_height);
    assign w_eff = (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH)
                                                        : CMP_W'(r_width);

    // ------------------------------------------------------------------
    // Request acceptance and pixel writes.
    // ------------------------------------------------------------------
    t_state                r_state;
    t_state                n_state;
    logic [NB_IDX_W-1:0]   r_cnt;
    logic [NB_IDX_W-1:0]   n_cnt;
    logic                  req_acc;
    logic                  wr_acc;
    logic                  smp_acc;
    logic                  interp_mode;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign wr_acc      = req_acc && (i_req.req_type == REQ_WRITE);
    assign smp_acc     = req_acc && (i_req.req_type == REQ_SAMPLE);
    assign interp_mode = (r_mode == MODE_NEAREST) || (r_mode == MODE_BILINEAR);

    logic [CMP_W-1:0]  wr_row_m1;
    logic [CMP_W-1:0]  wr_col_m1;
    logic              wr_in_range;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_pix;

    // Writes outside the store are dropped; writes outside the configured
    // image but inside the store are kept.
    assign wr_row_m1   = CMP_W'(i_req.pixel_row) - CMP_W'(1);
    assign wr_col_m1   = CMP_W'(i_req.pixel_col) - CMP_W'(1);
    assign wr_in_range = (i_req.pixel_row != '0) && (i_req.pixel_col != '0)
                      && (CMP_W'(i_req.pixel_row) <= CMP_W'(MAX_HEIGHT))
                      && (CMP_W'(i_req.pixel_col) <= CMP_W'(MAX_WIDTH));
    assign mem_we      = wr_acc && wr_in_range;
    assign wr_addr     = {wr_row_m1[ROW_AW-1:0], wr_col_m1[COL_AW-1:0]};
    assign wr_pix      = {i_req.pixel_c2, i_req.pixel_c1, i_req.pixel_c0};

    // ------------------------------------------------------------------
    // Sample setup. Nearest mode is folded into the blend: the chosen row
    // and column go in as the upper-left corner and both fractions become
    // zero, so all four fetches hit the same pixel and the lanes pass it.
    // ------------------------------------------------------------------
    logic [FRAC_BITS-1:0] s_fy;
    logic [FRAC_BITS-1:0] s_fx;
    logic [NB_W-1:0]      s_up;
    logic [NB_W-1:0]      s_left;
    logic [NB_W-1:0]      near_row;
    logic [NB_W-1:0]      near_col;

    assign s_fy     = i_req.sample_y[FRAC_BITS-1:0];
    assign s_fx     = i_req.sample_x[FRAC_BITS-1:0];
    assign s_up     = NB_W'(i_req.sample_y[COORD_W-1:FRAC_BITS]);
    assign s_left   = NB_W'(i_req.sample_x[COORD_W-1:FRAC_BITS]);
    // A tie at one half stays on the lower row or column.
    assign near_row = s_up + NB_W'(s_fy > FRAC_BITS'(HALF));
    assign near_col = s_left + NB_W'(s_fx > FRAC_BITS'(HALF));

    logic [NB_W-1:0] r_up;
    logic [NB_W-1:0] r_left;
    t_weights        r_wt;
    logic            r_white;

    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_white <= !interp_mode;
            if (r_mode == MODE_NEAREST) begin
                r_up    <= near_row;
                r_left  <= near_col;
                r_wt.fy <= '0;
                r_wt.fx <= '0;
            end else begin
                r_up    <= s_up;
                r_left  <= s_left;
                r_wt.fy <= s_fy;
                r_wt.fx <= s_fx;
            end
        end
    end

    // ------------------------------------------------------------------
    // Neighbor fetch: one store read per cycle in the order UL, UR, BL, BR.
    // A neighbor outside the image is flagged and replaced by white.
    // ------------------------------------------------------------------
    logic [NB_W-1:0]   nb_down;
    logic [NB_W-1:0]   nb_right;
    logic [NB_W-1:0]   rd_row;
    logic [NB_W-1:0]   rd_col;
    logic [CMP_W-1:0]  rd_row_m1;
    logic [CMP_W-1:0]  rd_col_m1;
    logic              rd_outside;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] mem_addr;
    logic [PIX_W-1:0]  mem_rdata;

    assign nb_down    = r_up + NB_W'(r_wt.fy != '0);
    assign nb_right   = r_left + NB_W'(r_wt.fx != '0);
    assign rd_row     = r_cnt[NB_ROW_BIT] ? nb_down : r_up;
    assign rd_col     = r_cnt[NB_COL_BIT] ? nb_right : r_left;
    assign rd_row_m1  = CMP_W'(rd_row) - CMP_W'(1);
    assign rd_col_m1  = CMP_W'(rd_col) - CMP_W'(1);
    assign rd_outside = (rd_row == '0) || (CMP_W'(rd_row) > h_eff)
                     || (rd_col == '0) || (CMP_W'(rd_col) > w_eff);
    assign rd_addr    = {rd_row_m1[ROW_AW-1:0], rd_col_m1[COL_AW-1:0]};
    assign mem_addr   = (r_state == S_READ) ? rd_addr : wr_addr;

    bis_frame_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (wr_pix),
        .o_rdata (mem_rdata)
    );

    // Store read data arrives in the cycle after the address, so the neighbor
    // index and the outside flag are registered once to stay aligned with it.
    logic                r_cap_vld;
    logic [NB_IDX_W-1:0] r_cap_idx;
    logic                r_cap_out;
    logic [PIX_W-1:0]    r_nb [NUM_NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_vld <= 1'b0;
        end else begin
            r_cap_vld <= (r_state == S_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap_idx <= r_cnt;
        r_cap_out <= rd_outside;
        if (r_cap_vld) begin
            r_nb[r_cap_idx] <= r_cap_out ? {PIX_W{1'b1}} : mem_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Channel lanes: one blend unit per channel, all fed the same weights.
    // ------------------------------------------------------------------
    t_chan lane_out [NUM_CHAN];

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        bis_lane u_lane (
            .i_clk  (i_clk),
            .i_wt   (r_wt),
            .i_ul   (r_nb[NB_UL][c*CHAN_W +: CHAN_W]),
            .i_ur   (r_nb[NB_UR][c*CHAN_W +: CHAN_W]),
            .i_bl   (r_nb[NB_BL][c*CHAN_W +: CHAN_W]),
            .i_br   (r_nb[NB_BR][c*CHAN_W +: CHAN_W]),
            .o_chan (lane_out[c])
        );
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = (r_state == S_DONE) && (!o_rsp.valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (smp_acc) begin
                    n_state = interp_mode ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                if (r_cnt == NB_LAST) begin
                    n_state = S_CALC;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + NB_IDX_W'(1);
                end
            end
            S_CALC: begin
                if (r_cnt == CALC_LAST) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + NB_IDX_W'(1);
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Merging stage and output register. The lanes' bytes are packed into
    // one pixel, or white is substituted in the constant-output modes.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] merged_pix;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;

    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            merged_pix[c*CHAN_W +: CHAN_W] = r_white ? {CHAN_W{1'b1}} : lane_out[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pix <= merged_pix;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.out_c0 = r_out_pix[0*CHAN_W +: CHAN_W];
    assign o_rsp.out_c1 = r_out_pix[1*CHAN_W +: CHAN_W];
    assign o_rsp.out_c2 = r_out_pix[2*CHAN_W +: CHAN_W];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_sample_starts_fetch, smp_acc && interp_mode |=> r_state == S_READ && r_cnt == '0, "interpolating sample did not start the neighbor fetch")
    `ASSERT_CLK(a_fetch_then_calc, r_state == S_READ && r_cnt == NB_LAST |=> r_state == S_CALC, "fetch of the last neighbor did not hand over to the lanes")
    `ASSERT_CLK(a_capture_after_read, r_cap_vld |-> $past(r_state == S_READ), "neighbor captured without a preceding store read")
    `ASSERT_CLK(a_result_from_done, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result appeared without a finished sample")

endmodule

// ===== design/bis_frame_store.sv =====
// Single-port frame store holding one packed pixel per entry.
// Depends on bis_pkg for depth and pixel width.
`timescale 1ns / 1ps

module bis_frame_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [bis_pkg::ADDR_W-1:0]  i_addr,
    input  logic [bis_pkg::PIX_W-1:0]   i_wdata,
    output logic [bis_pkg::PIX_W-1:0]   o_rdata
);
    import bis_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bis_lane.sv =====
// One channel lane: two-stage weighted blend of four neighbor bytes.
// Depends on bis_pkg for the weight struct and arithmetic widths.
`timescale 1ns / 1ps

module bis_lane (
    input  logic              i_clk,
    input  bis_pkg::t_weights i_wt,
    input  bis_pkg::t_chan    i_ul,
    input  bis_pkg::t_chan    i_ur,
    input  bis_pkg::t_chan    i_bl,
    input  bis_pkg::t_chan    i_br,
    output bis_pkg::t_chan    o_chan
);
    import bis_pkg::*;

    logic [WT_W-1:0]  inv_fx;
    logic [WT_W-1:0]  inv_fy;
    logic [TOP_W-1:0] n_top;
    logic [TOP_W-1:0] n_bot;
    logic [TOP_W-1:0] r_top;
    logic [TOP_W-1:0] r_bot;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] r_sum;

    assign inv_fx = WT_W'(SCALE) - WT_W'(i_wt.fx);
    assign inv_fy = WT_W'(SCALE) - WT_W'(i_wt.fy);

    // First stage blends along the row, second stage across the two rows.
    assign n_top = TOP_W'(inv_fx) * TOP_W'(i_ul) + TOP_W'(i_wt.fx) * TOP_W'(i_ur);
    assign n_bot = TOP_W'(inv_fx) * TOP_W'(i_bl) + TOP_W'(i_wt.fx) * TOP_W'(i_br);
    assign n_sum = SUM_W'(inv_fy) * SUM_W'(r_top) + SUM_W'(i_wt.fy) * SUM_W'(r_bot);

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_bot <= n_bot;
        r_sum <= n_sum;
    end

    // Dropping the fraction bits truncates toward zero.
    assign o_chan = r_sum[2*FRAC_BITS +: CHAN_W];

endmodule

// ===== test/tb_bilinear_image_sampler_unit.sv =====
// Self-checking testbench for bilinear_image_sampler_unit: random pixel writes and
// samples against a predictor of the frame store, over a series of register settings.
// Depends on bis_pkg, bis_if and the sampler RTL.
`timescale 1ns / 1ps

module tb_bilinear_image_sampler_unit;
    import bis_pkg::*;

    // One request as the generator plans it. Fields that the request kind does not
    // use are still filled with random values, since the block must ignore them.
    typedef struct {
        bit                 kind;
        bit [POS_W-1:0]     row;
        bit [POS_W-1:0]     col;
        bit [CHAN_W-1:0]    c0;
        bit [CHAN_W-1:0]    c1;
        bit [CHAN_W-1:0]    c2;
        bit [COORD_W-1:0]   y;
        bit [COORD_W-1:0]   x;
    } t_pixel_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    bis_req_if req_bus ();
    bis_rsp_if rsp_bus ();

    bilinear_image_sampler_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Register copies used by the predictor. They only change while the block is
    // idle, so every request is predicted with the setting it runs under.
    logic [MODE_W-1:0] cfg_mode   = MODE_RESET;
    logic [SIZE_W-1:0] cfg_height = HEIGHT_RESET;
    logic [SIZE_W-1:0] cfg_width  = WIDTH_RESET;

    // Predicted frame store contents, updated as write requests are accepted.
    logic [PIX_W-1:0] frame_copy [0:DEPTH-1];

    // Generator side: which entries will have been written by the time a planned
    // request runs. Samples are only planned when every neighbor inside the image
    // is already planned as written, so no unwritten entry is ever read.
    bit planned_wr [0:DEPTH-1];
    int written_cells[$];

    t_pixel_req       pending_reqs[$];
    logic [PIX_W-1:0] expected_pixels[$];

    int reqs_planned   = 0;
    int useful_planned = 0;
    int reqs_taken     = 0;
    int writes_taken   = 0;
    int samples_taken  = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int settings_run   = 1;

    // Percent chance per free cycle that the request side or the result side starts
    // a burst of idle cycles. Zero gives stretches of full throughput.
    int idle_pct  = 0;
    int stall_pct = 0;

    // Size saturation as the block applies it: a register above the store size
    // acts as the full store.
    function automatic int eff_height();
        return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
    endfunction

    function automatic int eff_width();
        return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
    endfunction

    // One neighbor of a sample; anything outside the configured image is white.
    function automatic logic [PIX_W-1:0] neighbor_pixel(input int r, input int c);
        if (r < 1 || r > eff_height() || c < 1 || c > eff_width())
            return {PIX_W{1'b1}};
        return frame_copy[(r - 1) * MAX_WIDTH + (c - 1)];
    endfunction

    // Expected pixel for a sample at fixed-point position (y, x) under the
    // current mode. Nearest mode breaks a tie toward the lower row or column;
    // bilinear mode blends exactly and truncates.
    function automatic logic [PIX_W-1:0] predict_sample(input bit [COORD_W-1:0] y,
                                                        input bit [COORD_W-1:0] x);
        longint unsigned fy, fx, top, bot, sum;
        int              up, left, down, right, k;
        logic [PIX_W-1:0] ul, ur, bl, br, res;
        fy    = y[FRAC_BITS-1:0];
        fx    = x[FRAC_BITS-1:0];
        up    = y >> FRAC_BITS;
        left  = x >> FRAC_BITS;
        down  = up + ((fy != 0) ? 1 : 0);
        right = left + ((fx != 0) ? 1 : 0);
        res   = {PIX_W{1'b1}};
        case (cfg_mode)
            MODE_NEAREST: begin
                res = neighbor_pixel(((SCALE - fy) < fy) ? down : up,
                                     ((SCALE - fx) < fx) ? right : left);
            end
            MODE_BILINEAR: begin
                ul = neighbor_pixel(up, left);
                ur = neighbor_pixel(up, right);
                bl = neighbor_pixel(down, left);
                br = neighbor_pixel(down, right);
                for (k = 0; k < NUM_CHAN; k++) begin
                    top = (SCALE - fx) * ul[CHAN_W*k +: CHAN_W]
                        + fx * ur[CHAN_W*k +: CHAN_W];
                    bot = (SCALE - fx) * bl[CHAN_W*k +: CHAN_W]
                        + fx * br[CHAN_W*k +: CHAN_W];
                    sum = (SCALE - fy) * top + fy * bot;
                    res[CHAN_W*k +: CHAN_W] = CHAN_W'(sum >> (2 * FRAC_BITS));
                end
            end
            default: res = {PIX_W{1'b1}};
        endcase
        return res;
    endfunction

    // Effect of one accepted request: a write updates the store copy (writes
    // outside the store are dropped), a sample queues its expected pixel.
    task automatic take_request(input t_pixel_req it);
        reqs_taken++;
        if (it.kind == REQ_WRITE) begin
            writes_taken++;
            if (it.row >= 1 && it.row <= MAX_HEIGHT && it.col >= 1 && it.col <= MAX_WIDTH)
                frame_copy[(it.row - 1) * MAX_WIDTH + (it.col - 1)] = {it.c2, it.c1, it.c0};
        end else begin
            samples_taken++;
            expected_pixels.push_back(predict_sample(it.y, it.x));
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver. A new request is presented whenever the bus slot is free;
    // random idle bursts are inserted between requests.
    // ------------------------------------------------------------------
    t_pixel_req cur_req;
    int         gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (req_bus.valid && req_bus.ready)
                take_request(cur_req);
            if (!req_bus.valid || req_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end else if (pending_reqs.size() != 0 && idle_pct != 0
                             && $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(0, 12);
                    req_bus.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_bus.valid     <= 1'b1;
                    req_bus.req_type  <= cur_req.kind;
                    req_bus.pixel_row <= cur_req.row;
                    req_bus.pixel_col <= cur_req.col;
                    req_bus.pixel_c0  <= cur_req.c0;
                    req_bus.pixel_c1  <= cur_req.c1;
                    req_bus.pixel_c2  <= cur_req.c2;
                    req_bus.sample_y  <= cur_req.y;
                    req_bus.sample_x  <= cur_req.x;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Each accepted result is checked channel by channel against
    // the oldest expected pixel. Ready is dropped in random stall bursts.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] got_pixel;
    logic [PIX_W-1:0] want_pixel;
    int               stall_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                results_seen++;
                got_pixel = {rsp_bus.out_c2, rsp_bus.out_c1, rsp_bus.out_c0};
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Result %0d arrived with no sample pending: ",
                                  "c0/c1/c2 = %0d/%0d/%0d"},
                                 results_seen, got_pixel[7:0], got_pixel[15:8],
                                 got_pixel[23:16]);
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    if (got_pixel[7:0] !== want_pixel[7:0]
                        || got_pixel[15:8] !== want_pixel[15:8]
                        || got_pixel[23:16] !== want_pixel[23:16]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Result %0d: expected c0/c1/c2 = %0d/%0d/%0d, ",
                                      "got %0d/%0d/%0d"},
                                     results_seen, want_pixel[7:0], want_pixel[15:8],
                                     want_pixel[23:16], got_pixel[7:0], got_pixel[15:8],
                                     got_pixel[23:16]);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 12);
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus planning.
    // ------------------------------------------------------------------

    // Channel bytes lean toward the extremes.
    function automatic bit [CHAN_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Fractions lean toward zero (integer position), the half-way tie and its
    // neighbors, and the ends of the range.
    function automatic int pick_frac();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return HALF;
            2:       return HALF - 1 + 2 * $urandom_range(0, 1);
            3:       return $urandom_range(0, 1) ? SCALE - 1 : 1;
            default: return $urandom_range(0, SCALE - 1);
        endcase
    endfunction

    function automatic t_pixel_req random_fields();
        t_pixel_req it;
        it.kind = 1'($urandom_range(0, 1));
        it.row  = POS_W'($urandom_range(0, 511));
        it.col  = POS_W'($urandom_range(0, 511));
        it.c0   = pick_byte();
        it.c1   = pick_byte();
        it.c2   = pick_byte();
        it.y    = COORD_W'($urandom_range(0, 131071));
        it.x    = COORD_W'($urandom_range(0, 131071));
        return it;
    endfunction

    // Queues a request and records what the store will hold once it has run.
    // Writes that fall outside the store are ignored by the block and so are not
    // counted toward the size of a phase.
    task automatic plan(input t_pixel_req it);
        int idx;
        pending_reqs.push_back(it);
        reqs_planned++;
        if (it.kind == REQ_WRITE) begin
            if (it.row >= 1 && it.row <= MAX_HEIGHT && it.col >= 1 && it.col <= MAX_WIDTH) begin
                idx = (it.row - 1) * MAX_WIDTH + (it.col - 1);
                if (!planned_wr[idx]) begin
                    planned_wr[idx] = 1'b1;
                    written_cells.push_back(idx);
                end
                useful_planned++;
            end
        end else begin
            useful_planned++;
        end
    endtask

    task automatic plan_write(input int r, input int c, input bit [7:0] b0,
                              input bit [7:0] b1, input bit [7:0] b2);
        t_pixel_req it;
        it      = random_fields();
        it.kind = REQ_WRITE;
        it.row  = POS_W'(r);
        it.col  = POS_W'(c);
        it.c0   = b0;
        it.c1   = b1;
        it.c2   = b2;
        plan(it);
    endtask

    task automatic plan_sample(input int y, input int x);
        t_pixel_req it;
        it      = random_fields();
        it.kind = REQ_SAMPLE;
        it.y    = COORD_W'(y);
        it.x    = COORD_W'(x);
        plan(it);
    endtask

    // Finds a neighbor of (y, x) inside the image that no planned write has
    // covered yet. All four neighbors are checked whatever the mode.
    function automatic bit find_gap(input bit [COORD_W-1:0] y, input bit [COORD_W-1:0] x,
                                    output int mr, output int mc);
        int ys[2];
        int xs[2];
        int i, j;
        ys[0] = y >> FRAC_BITS;
        ys[1] = ys[0] + ((y[FRAC_BITS-1:0] != 0) ? 1 : 0);
        xs[0] = x >> FRAC_BITS;
        xs[1] = xs[0] + ((x[FRAC_BITS-1:0] != 0) ? 1 : 0);
        mr = 0;
        mc = 0;
        for (i = 0; i < 2; i++) begin
            for (j = 0; j < 2; j++) begin
                if (ys[i] >= 1 && ys[i] <= eff_height()
                    && xs[j] >= 1 && xs[j] <= eff_width()
                    && !planned_wr[(ys[i] - 1) * MAX_WIDTH + (xs[j] - 1)]) begin
                    mr = ys[i];
                    mc = xs[j];
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // One random request. Most samples sit on or next to a written pixel inside
    // the image; the rest spread over the image and over the full coordinate
    // range. A sample that would touch an unwritten pixel becomes a write of
    // that pixel instead, so the image fills in around where it is sampled.
    task automatic plan_random();
        int hs, ws, r, c, p, mr, mc, roll;
        bit [COORD_W-1:0] y, x;
        hs   = (eff_height() == 0) ? MAX_HEIGHT : eff_height();
        ws   = (eff_width() == 0) ? MAX_WIDTH : eff_width();
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            if ($urandom_range(0, 9) == 0)
                plan_write($urandom_range(0, 511), $urandom_range(0, 511),
                           pick_byte(), pick_byte(), pick_byte());
            else
                plan_write($urandom_range(1, hs), $urandom_range(1, ws),
                           pick_byte(), pick_byte(), pick_byte());
        end else begin
            if (roll < 80) begin
                r = $urandom_range(1, hs);
                c = $urandom_range(1, ws);
                if (written_cells.size() != 0) begin
                    p = written_cells[$urandom_range(0, written_cells.size() - 1)];
                    if (p / MAX_WIDTH < hs && p % MAX_WIDTH < ws) begin
                        r = p / MAX_WIDTH + 1;
                        c = p % MAX_WIDTH + 1;
                    end
                end
                r = r - $urandom_range(0, 1);
                c = c - $urandom_range(0, 1);
                y = COORD_W'(r * SCALE + pick_frac());
                x = COORD_W'(c * SCALE + pick_frac());
            end else if (roll < 90) begin
                y = COORD_W'($urandom_range(0, (hs + 1) * SCALE));
                x = COORD_W'($urandom_range(0, (ws + 1) * SCALE));
            end else begin
                y = COORD_W'($urandom_range(0, 131071));
                x = COORD_W'($urandom_range(0, 131071));
            end
            if (find_gap(y, x, mr, mc))
                plan_write(mr, mc, pick_byte(), pick_byte(), pick_byte());
            else
                plan_sample(y, x);
        end
    endtask

    task automatic plan_randoms(input int count);
        int target;
        target = useful_planned + count;
        while (useful_planned < target)
            plan_random();
    endtask

    // Waits until every planned request has been taken and every result has
    // come back, then lets the block drain: a trailing write yields no result
    // and may still be in flight.
    task automatic settle();
        while (reqs_taken != reqs_planned || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the data at
    // the edge where psel, penable, pwrite and pready are all high.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input int unsigned data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODE:   cfg_mode   = MODE_W'(data);
            REG_HEIGHT: cfg_height = SIZE_W'(data);
            REG_WIDTH:  cfg_width  = SIZE_W'(data);
            default:    ;
        endcase
    endtask

    // Moves the block to a new setting once it is idle, and picks how much
    // idling each side does during the coming phase.
    task automatic configure(input int mode, input int height, input int width,
                             input bit with_idle);
        settle();
        write_register(REG_MODE, mode);
        write_register(REG_HEIGHT, height);
        write_register(REG_WIDTH, width);
        settings_run++;
        idle_pct  = with_idle ? 15 * $urandom_range(0, 2) : 0;
        stall_pct = with_idle ? 15 * $urandom_range(0, 2) : 0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_bus.valid     = 1'b0;
        req_bus.req_type  = REQ_WRITE;
        req_bus.pixel_row = '0;
        req_bus.pixel_col = '0;
        req_bus.pixel_c0  = '0;
        req_bus.pixel_c1  = '0;
        req_bus.pixel_c2  = '0;
        req_bus.sample_y  = '0;
        req_bus.sample_x  = '0;
        rsp_bus.ready     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: bilinear over the full 256 x 256 image.
        idle_pct  = 15;
        stall_pct = 15;
        plan_write(1, 1, 8'h00, 8'h00, 8'h00);
        plan_write(1, 2, 8'hFF, 8'hFF, 8'hFF);
        plan_write(2, 1, 8'h12, 8'h34, 8'h56);
        plan_write(2, 2, 8'hFF, 8'h00, 8'h80);
        plan_write(255, 255, pick_byte(), pick_byte(), pick_byte());
        plan_write(255, 256, 8'h01, 8'hFE, 8'h7F);
        plan_write(256, 255, 8'h80, 8'h00, 8'hFF);
        plan_write(256, 256, 8'hFF, 8'hFF, 8'hFF);
        // Writes with a zero or too large row or column are dropped by the block.
        plan_write(0, 5, 8'hAA, 8'hAA, 8'hAA);
        plan_write(5, 0, 8'h55, 8'h55, 8'h55);
        plan_write(257, 1, 8'h00, 8'hFF, 8'h00);
        plan_write(511, 511, 8'hFF, 8'h00, 8'hFF);
        // Integer position, centered blends, an uneven blend, the far corner of
        // the image (three of its four neighbors outside), the origin and the largest
        // position (all neighbors outside).
        plan_sample(1 * SCALE, 1 * SCALE);
        plan_sample(1 * SCALE + HALF, 1 * SCALE + HALF);
        plan_sample(1 * SCALE + HALF, 1 * SCALE);
        plan_sample(2 * SCALE - 1, 1 * SCALE + 1);
        plan_sample(255 * SCALE + HALF, 255 * SCALE + HALF);
        plan_sample(256 * SCALE + HALF, 256 * SCALE + HALF);
        plan_sample(0, 0);
        plan_sample(131071, 131071);
        plan_randoms(180);

        // Nearest neighbor on a small image, starting with the tie rules: an
        // exact half goes to the lower row or column, just past it goes up.
        configure(MODE_NEAREST, 8, 8, 1'b1);
        plan_sample(1 * SCALE + HALF, 1 * SCALE + HALF);
        plan_sample(1 * SCALE + HALF + 1, 1 * SCALE + HALF - 1);
        plan_sample(1 * SCALE, 2 * SCALE - 1);
        plan_randoms(170);

        // Single-pixel image, then the white modes with a zero width and an
        // oversized height, then a zero height under bilinear.
        configure(MODE_BILINEAR, 1, 1, 1'b1);
        plan_randoms(100);
        configure(MODE_WHITE, 16, 0, 1'b1);
        plan_randoms(70);
        configure(MODE_RESERVED, 511, 2, 1'b1);
        plan_randoms(70);
        configure(MODE_BILINEAR, 0, 256, 1'b1);
        plan_randoms(70);

        // Full store with the width saturated, then assorted shapes.
        configure(MODE_NEAREST, 256, 511, 1'b1);
        plan_randoms(200);
        configure(MODE_BILINEAR, 5, 12, 1'b1);
        plan_randoms(170);
        configure(MODE_NEAREST, 1, 256, 1'b1);
        plan_randoms(120);

        // Last phase runs at full throughput on both sides.
        configure(MODE_BILINEAR, 33, 20, 1'b0);
        plan_randoms(180);

        settle();
        $display("Ran %0d writes and %0d samples over %0d register settings,", writes_taken,
                 samples_taken, settings_run);
        $display("covering all modes, zero, single and oversized image sizes; %0d results.",
                 results_seen);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("tb_bilinear_image_sampler_unit OK");
        else
            $display("tb_bilinear_image_sampler_unit NOT OK");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial begin
        #5000000;
        $display("Timeout: %0d of %0d requests taken, %0d results outstanding", reqs_taken,
                 reqs_planned, expected_pixels.size());
        $display("tb_bilinear_image_sampler_unit NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/bis_pkg.sv
design/bis_if.sv
design/bis_frame_store.sv
design/bis_lane.sv
design/bilinear_image_sampler_unit.sv
test/tb_bilinear_image_sampler_unit.sv
